// ===== rtl/psjd_pkg.sv =====
// Shared types and constants of the per-server job dispatcher.
// Used by the top level and its checker; depends on nothing.
`timescale 1ns / 1ps

package psjd_pkg;

    localparam int MAX_SERVERS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 256;

    localparam int JOB_W  = 16;
    localparam int SRV_W  = 5;
    localparam int TURN_W = 8;
    localparam int CFG_W  = 8;

    localparam logic [TURN_W-1:0] INITIAL_TURN_RST = 8'd100;
    localparam logic [SRV_W-1:0]  SERVER_COUNT_RST = 5'd16;

    localparam logic CFG_INITIAL_TURN = 1'b0;
    localparam logic CFG_SERVER_COUNT = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ENQUEUE  = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_SERVER = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode          opcode;
        logic [JOB_W-1:0] job_id;
        logic [SRV_W-1:0] server;
    } t_in_item;

    typedef struct packed {
        logic [JOB_W-1:0] out_job;
        logic [SRV_W-1:0] out_server;
        t_status          status;
    } t_out_item;

endpackage

// ===== rtl/per_server_job_dispatcher.sv =====
// Top level of the per-server job dispatcher: queue metadata memory, job store, output register.
// Depends on psjd_pkg.
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data   (t_in_item)
// out      output     o_out_valid / i_out_ready  o_out_data  (t_out_item)
// cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Clear, enqueue, no-op and a dispatch that finds every queue empty end in S_RMW; a dispatch
// that finds a job goes on to S_OUT. The metadata memory is read on accept; S_RMW updates and
// writes it back and reads the job store. One transaction is in flight at a time.
// Reset is synchronous; per-server valid bits make every queue empty at once, no sweep.
// A full output register holds the result stage until the transaction is taken;
// the configuration port is always ready.
`timescale 1ns / 1ps

module per_server_job_dispatcher
    import psjd_pkg::*;
#(
    parameter int MAX_SERVERS = MAX_SERVERS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int HEAD_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int AW     = $clog2(MAX_SERVERS * QUEUE_DEPTH);

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [CNT_W-1:0]  count;
        logic [TURN_W-1:0] turn;
    } t_meta;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RMW  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_meta            meta_mem [MAX_SERVERS];
    logic [JOB_W-1:0] job_mem  [MAX_SERVERS * QUEUE_DEPTH];

    t_state            r_state, n_state;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic [TURN_W-1:0] r_initial_turn;
    logic [SRV_W-1:0]  r_server_count;
    logic [TURN_W-1:0] r_clear_turn;
    logic [MAX_SERVERS-1:0] r_meta_vld;
    logic [MAX_SERVERS-1:0] r_nonempty;
    logic [SRV_W-1:0]  r_next_server;

    t_opcode           r_op;
    logic [JOB_W-1:0]  r_job;
    logic [SRV_W-1:0]  r_srv;
    logic [IDX_W-1:0]  r_idx;
    logic              r_found;
    logic              r_bad;
    t_meta             r_meta_rd;
    logic              r_meta_valid_rd;
    logic [JOB_W-1:0]  r_job_rd;

    logic              in_acc;
    logic              out_free;
    logic [SRV_W-1:0]  srv_used;
    logic [SRV_W-1:0]  start_srv;
    logic              found_hi, found_lo, disp_found;
    logic [IDX_W-1:0]  pick_hi, pick_lo, disp_idx;
    logic [6:0]        enq_srv_m1;
    logic [IDX_W-1:0]  enq_idx, acc_idx;
    logic [SRV_W-1:0]  acc_srv;
    logic              enq_bad;

    t_meta             cur, n_meta;
    logic [SUM_W-1:0]  sum, sum_tail, enq_wrap, tail_wrap;
    logic [HEAD_W-1:0] head_next, pos;
    logic              full;
    logic              go;
    logic              meta_we, store_we, store_re, clear_do, disp_do, out_load;
    logic [AW-1:0]     store_addr;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_server_count == '0) begin
            srv_used = SRV_W'(1);
        end else if (int'(r_server_count) > MAX_SERVERS) begin
            srv_used = SRV_W'(MAX_SERVERS);
        end else begin
            srv_used = r_server_count;
        end
        if (r_next_server == '0 || r_next_server > srv_used) begin
            start_srv = SRV_W'(1);
        end else begin
            start_srv = r_next_server;
        end
    end

    always_comb begin
        found_hi = 1'b0;
        found_lo = 1'b0;
        pick_hi  = '0;
        pick_lo  = '0;
        for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
            if (r_nonempty[i] && i < int'(srv_used)) begin
                found_lo = 1'b1;
                pick_lo  = IDX_W'(i);
                if (i + 1 >= int'(start_srv)) begin
                    found_hi = 1'b1;
                    pick_hi  = IDX_W'(i);
                end
            end
        end
        disp_found = found_hi || found_lo;
        disp_idx   = found_hi ? pick_hi : pick_lo;
    end

    assign enq_srv_m1 = {2'b00, i_in_data.server} - 7'd1;
    assign enq_idx    = enq_srv_m1[IDX_W-1:0];
    assign enq_bad    = (i_in_data.server == '0) || (i_in_data.server > srv_used);
    assign acc_idx    = (i_in_data.opcode == OP_DISPATCH) ? disp_idx : enq_idx;
    assign acc_srv    = (i_in_data.opcode == OP_DISPATCH) ? SRV_W'(disp_idx) + SRV_W'(1)
                                                          : i_in_data.server;

    always_comb begin
        if (r_meta_valid_rd) begin
            cur = r_meta_rd;
        end else begin
            cur = '{head: '0, count: '0, turn: r_clear_turn};
        end
    end

    assign sum       = SUM_W'(cur.head) + SUM_W'(cur.count);
    assign sum_tail  = sum - SUM_W'(1);
    assign enq_wrap  = (sum >= SUM_W'(QUEUE_DEPTH)) ? sum - SUM_W'(QUEUE_DEPTH) : sum;
    assign tail_wrap = (sum_tail >= SUM_W'(QUEUE_DEPTH)) ? sum_tail - SUM_W'(QUEUE_DEPTH)
                                                          : sum_tail;
    assign head_next = (cur.head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : cur.head + HEAD_W'(1);
    assign full      = (cur.count == CNT_W'(QUEUE_DEPTH));
    assign go        = (r_op == OP_DISPATCH && r_found) || out_free;

    always_comb begin
        n_state  = r_state;
        n_meta   = cur;
        n_out    = '{out_job: '0, out_server: '0, status: ST_OK};
        pos      = enq_wrap[HEAD_W-1:0];
        meta_we  = 1'b0;
        store_we = 1'b0;
        store_re = 1'b0;
        clear_do = 1'b0;
        disp_do  = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                if (go) begin
                    case (r_op)
                        OP_CLEAR: begin
                            clear_do = 1'b1;
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                        OP_ENQUEUE: begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                            if (r_bad) begin
                                n_out.status = ST_BAD_SERVER;
                            end else if (full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                store_we     = 1'b1;
                                meta_we      = 1'b1;
                                n_meta.count = cur.count + CNT_W'(1);
                            end
                        end
                        OP_DISPATCH: begin
                            if (!r_found) begin
                                n_out.status = ST_EMPTY;
                                out_load     = 1'b1;
                                n_state      = S_IDLE;
                            end else begin
                                meta_we      = 1'b1;
                                store_re     = 1'b1;
                                disp_do      = 1'b1;
                                n_meta.count = cur.count - CNT_W'(1);
                                if (cur.turn != '0) begin
                                    pos         = tail_wrap[HEAD_W-1:0];
                                    n_meta.turn = cur.turn - TURN_W'(1);
                                end else begin
                                    pos         = cur.head;
                                    n_meta.head = head_next;
                                    n_meta.turn = cur.turn + TURN_W'(1);
                                end
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                            n_state  = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUT: begin
                n_out = '{out_job: r_job_rd, out_server: r_srv, status: ST_OK};
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign store_addr = AW'(r_idx) * AW'(QUEUE_DEPTH) + AW'(pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_initial_turn <= INITIAL_TURN_RST;
            r_server_count <= SERVER_COUNT_RST;
            r_clear_turn   <= INITIAL_TURN_RST;
            r_meta_vld     <= '0;
            r_nonempty     <= '0;
            r_next_server  <= SRV_W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_INITIAL_TURN: r_initial_turn <= i_cfg_data;
                    CFG_SERVER_COUNT: r_server_count <= i_cfg_data[SRV_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end
            if (meta_we) begin
                r_meta_vld[r_idx] <= 1'b1;
                r_nonempty[r_idx] <= (n_meta.count != '0);
            end
            if (disp_do) begin
                r_next_server <= (r_srv >= srv_used) ? SRV_W'(1) : r_srv + SRV_W'(1);
            end
            if (clear_do) begin
                r_meta_vld    <= '0;
                r_nonempty    <= '0;
                r_next_server <= SRV_W'(1);
                r_clear_turn  <= r_initial_turn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op            <= i_in_data.opcode;
            r_job           <= i_in_data.job_id;
            r_srv           <= acc_srv;
            r_idx           <= acc_idx;
            r_found         <= disp_found;
            r_bad           <= enq_bad;
            r_meta_rd       <= meta_mem[acc_idx];
            r_meta_valid_rd <= r_meta_vld[acc_idx];
        end
        if (meta_we) begin
            meta_mem[r_idx] <= n_meta;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            job_mem[store_addr] <= r_job;
        end
        if (store_re) begin
            r_job_rd <= job_mem[store_addr];
        end
    end

endmodule

// ===== rtl/psjd_checker.sv =====
// Port-level checker for the per-server job dispatcher, bound to the top level.
// Depends on psjd_pkg and per_server_job_dispatcher.
`timescale 1ns / 1ps

module psjd_checker
    import psjd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_item        o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction accepted while one is in flight");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    a_fail_no_server: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |->
            o_out_data.out_server == '0 && o_out_data.out_job == '0)
        else $error("failed transaction carries a job");

endmodule

bind per_server_job_dispatcher psjd_checker u_psjd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
